/* rtl/lbcp_pkg.sv */
// Package for the LED blink command parser: shared constants, codes and item types.
// Used by lbcp_front, lbcp_queue, lbcp_back and led_blink_command_parser.
package lbcp_pkg;

    localparam int LINE_KEEP_DEF = 63;
    localparam int NUM_LEDS      = 3;
    localparam int LED_W         = 2;
    localparam int PERIOD_W      = 16;
    localparam int HALF_W        = 15;
    localparam int ACC_W         = 17;
    localparam int CFG_IDX_W     = 1;
    localparam int DIGIT_W       = 4;

    localparam logic [ACC_W-1:0]    ACC_SAT          = 17'd65536;
    localparam logic [ACC_W-1:0]    ACC_LIMIT        = 17'd6553;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 16'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN_RESET = 16'd50;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX_RESET = 16'd10000;
    localparam logic [HALF_W-1:0]   HALF_RESET       = 15'd500;

    localparam logic [2:0] PS_L     = 3'd0;
    localparam logic [2:0] PS_E     = 3'd1;
    localparam logic [2:0] PS_D     = 3'd2;
    localparam logic [2:0] PS_NUM   = 3'd3;
    localparam logic [2:0] PS_COLON = 3'd4;
    localparam logic [2:0] PS_DONE  = 3'd5;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_D     = 8'h44;
    localparam logic [7:0] CHAR_E     = 8'h45;
    localparam logic [7:0] CHAR_L     = 8'h4C;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        OP_CHAR,
        OP_EOL,
        OP_TICK
    } op_t;

    typedef enum logic [3:0] {
        CLS_NUL,
        CLS_L,
        CLS_E,
        CLS_D,
        CLS_COLON,
        CLS_BLANK,
        CLS_PLUS,
        CLS_MINUS,
        CLS_DIGIT,
        CLS_OTHER
    } cls_t;

    typedef enum logic [1:0] {
        NP_BLANKS,
        NP_DIGITS,
        NP_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_REJECT = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_MIN = 1'b0,
        CFG_PERIOD_MAX = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        op_t                op;
        cls_t               cls;
        logic [DIGIT_W-1:0] digit;
    } item_t;

endpackage

/* rtl/lbcp_front.sv */
// Front end: accepts input items and classifies each byte into a parser operation.
// Depends on lbcp_pkg; feeds lbcp_queue.
module lbcp_front (
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           kind,
    input  logic [7:0]     rx_data,
    input  logic           q_full,
    output logic           push,
    output lbcp_pkg::item_t push_item
);
    import lbcp_pkg::*;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_item.digit = rx_data[DIGIT_W-1:0];
        push_item.cls   = CLS_OTHER;
        push_item.op    = OP_CHAR;
        if (kind == KIND_TICK)
        begin
            push_item.op = OP_TICK;
        end
        else if (rx_data == CHAR_LF || rx_data == CHAR_CR)
        begin
            push_item.op = OP_EOL;
        end
        priority if (rx_data == CHAR_NUL)
            push_item.cls = CLS_NUL;
        else if (rx_data == CHAR_L)
            push_item.cls = CLS_L;
        else if (rx_data == CHAR_E)
            push_item.cls = CLS_E;
        else if (rx_data == CHAR_D)
            push_item.cls = CLS_D;
        else if (rx_data == CHAR_COLON)
            push_item.cls = CLS_COLON;
        else if (rx_data == CHAR_SPACE || rx_data == CHAR_TAB ||
                 rx_data == CHAR_VT || rx_data == CHAR_FF)
            push_item.cls = CLS_BLANK;
        else if (rx_data == CHAR_PLUS)
            push_item.cls = CLS_PLUS;
        else if (rx_data == CHAR_MINUS)
            push_item.cls = CLS_MINUS;
        else if (rx_data >= CHAR_ZERO && rx_data <= CHAR_NINE)
            push_item.cls = CLS_DIGIT;
        else
            push_item.cls = CLS_OTHER;
    end

endmodule

/* rtl/lbcp_queue.sv */
// Two-entry queue of classified items between the front end and the back end.
// Depends on lbcp_pkg.
module lbcp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lbcp_pkg::item_t push_item,
    output logic            q_full,
    output logic            q_valid,
    input  logic            pop,
    output lbcp_pkg::item_t q_item
);
    import lbcp_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign q_full  = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/lbcp_back.sv */
// Back end: line parser, LED blinkers, configuration registers and the result register.
// Depends on lbcp_pkg; takes items from lbcp_queue.
module lbcp_back #(
    parameter int LINE_KEEP = lbcp_pkg::LINE_KEEP_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_valid,
    input  lbcp_pkg::item_t                       q_item,
    output logic                                  pop,
    input  logic                                  cfg_we,
    input  logic [lbcp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lbcp_pkg::PERIOD_W-1:0]         cfg_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [lbcp_pkg::NUM_LEDS-1:0]         led_mask,
    output logic [1:0]                            cmd_status,
    output logic [lbcp_pkg::LED_W-1:0]            cmd_led,
    output logic [lbcp_pkg::PERIOD_W-1:0]         cmd_period
);
    import lbcp_pkg::*;

    localparam int LC_W = $clog2(LINE_KEEP + 1);
    localparam logic [LC_W-1:0] LC_KEEP = LC_W'(LINE_KEEP);

    logic [PERIOD_W-1:0] period_min_reg;
    logic [PERIOD_W-1:0] period_max_reg;

    logic [LC_W-1:0]     line_count_reg,   line_count_next;
    logic [2:0]          prefix_state_reg, prefix_state_next;
    logic                prefix_bad_reg,   prefix_bad_next;
    logic [LED_W-1:0]    target_led_reg,   target_led_next;
    phase_t              phase_reg,        phase_next;
    logic                minus_seen_reg,   minus_seen_next;
    logic [ACC_W-1:0]    acc_reg,          acc_next;
    logic                text_ended_reg,   text_ended_next;

    logic [PERIOD_W-1:0] period_reg  [NUM_LEDS];
    logic [PERIOD_W-1:0] period_next [NUM_LEDS];
    logic [HALF_W-1:0]   half_reg    [NUM_LEDS];
    logic [HALF_W-1:0]   half_next   [NUM_LEDS];
    logic [HALF_W-1:0]   elapsed_reg [NUM_LEDS];
    logic [HALF_W-1:0]   elapsed_next[NUM_LEDS];
    logic [NUM_LEDS-1:0] lit_reg,    lit_next;

    logic                out_valid_reg,  out_valid_next;
    logic [NUM_LEDS-1:0] out_mask_reg,   out_mask_next;
    status_t             out_status_reg, out_status_next;
    logic [LED_W-1:0]    out_led_reg,    out_led_next;
    logic [PERIOD_W-1:0] out_period_reg, out_period_next;

    logic [ACC_W-1:0]    acc_added;
    logic                prefix_ok;
    logic                cmd_ok;

    assign pop        = q_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign led_mask   = out_mask_reg;
    assign cmd_status = out_status_reg;
    assign cmd_led    = out_led_reg;
    assign cmd_period = out_period_reg;

    always_comb
    begin
        logic [ACC_W-1:0] acc_sum;
        acc_sum = {acc_reg[ACC_W-4:0], 3'b000} + {acc_reg[ACC_W-2:0], 1'b0}
                + {{(ACC_W-DIGIT_W){1'b0}}, q_item.digit};
        if (acc_reg > ACC_LIMIT || acc_sum > ACC_SAT)
            acc_added = ACC_SAT;
        else
            acc_added = acc_sum;
    end

    always_comb
    begin
        cmd_ok = (prefix_state_reg == PS_DONE) && !prefix_bad_reg
              && !(minus_seen_reg && acc_reg != '0)
              && (acc_reg >= {1'b0, period_min_reg})
              && (acc_reg <= {1'b0, period_max_reg});
    end

    always_comb
    begin
        line_count_next   = line_count_reg;
        prefix_state_next = prefix_state_reg;
        prefix_bad_next   = prefix_bad_reg;
        target_led_next   = target_led_reg;
        phase_next        = phase_reg;
        minus_seen_next   = minus_seen_reg;
        acc_next          = acc_reg;
        text_ended_next   = text_ended_reg;
        period_next       = period_reg;
        half_next         = half_reg;
        elapsed_next      = elapsed_reg;
        lit_next          = lit_reg;
        out_mask_next     = out_mask_reg;
        out_status_next   = out_status_reg;
        out_led_next      = out_led_reg;
        out_period_next   = out_period_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        prefix_ok         = 1'b0;

        if (pop)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ST_NONE;
            out_led_next    = '0;
            out_period_next = '0;
            unique case (q_item.op)
                OP_TICK:
                begin
                    for (int i = 0; i < NUM_LEDS; i++)
                    begin
                        elapsed_next[i] = elapsed_reg[i] + HALF_W'(1);
                        if (elapsed_next[i] >= half_reg[i])
                        begin
                            lit_next[i]     = !lit_reg[i];
                            elapsed_next[i] = '0;
                            half_next[i]    = period_reg[i][PERIOD_W-1:1];
                        end
                    end
                end
                OP_EOL:
                begin
                    if (line_count_reg != '0)
                    begin
                        if (cmd_ok)
                        begin
                            for (int i = 0; i < NUM_LEDS; i++)
                            begin
                                if (target_led_reg == LED_W'(i))
                                    period_next[i] = acc_reg[PERIOD_W-1:0];
                            end
                            out_status_next = ST_ACCEPT;
                            out_led_next    = target_led_reg;
                            out_period_next = acc_reg[PERIOD_W-1:0];
                        end
                        else
                        begin
                            out_status_next = ST_REJECT;
                        end
                        line_count_next   = '0;
                        prefix_state_next = PS_L;
                        prefix_bad_next   = 1'b0;
                        target_led_next   = '0;
                        phase_next        = NP_BLANKS;
                        minus_seen_next   = 1'b0;
                        acc_next          = '0;
                        text_ended_next   = 1'b0;
                    end
                end
                default:
                begin
                    if (line_count_reg < LC_KEEP && !text_ended_reg)
                    begin
                        line_count_next = line_count_reg + LC_W'(1);
                        if (q_item.cls == CLS_NUL)
                        begin
                            text_ended_next = 1'b1;
                        end
                        else if (prefix_state_reg < PS_DONE)
                        begin
                            if (!prefix_bad_reg)
                            begin
                                unique case (prefix_state_reg)
                                    PS_L:   prefix_ok = (q_item.cls == CLS_L);
                                    PS_E:   prefix_ok = (q_item.cls == CLS_E);
                                    PS_D:   prefix_ok = (q_item.cls == CLS_D);
                                    PS_NUM:
                                    begin
                                        prefix_ok = (q_item.cls == CLS_DIGIT)
                                            && (q_item.digit >= DIGIT_W'(1))
                                            && (q_item.digit <= DIGIT_W'(NUM_LEDS));
                                        if (prefix_ok)
                                            target_led_next =
                                                LED_W'(q_item.digit - DIGIT_W'(1));
                                    end
                                    default: prefix_ok = (q_item.cls == CLS_COLON);
                                endcase
                                if (prefix_ok)
                                    prefix_state_next = prefix_state_reg + 3'd1;
                                else
                                    prefix_bad_next = 1'b1;
                            end
                        end
                        else
                        begin
                            unique case (phase_reg)
                                NP_BLANKS:
                                begin
                                    priority if (q_item.cls == CLS_BLANK)
                                    begin
                                        phase_next = NP_BLANKS;
                                    end
                                    else if (q_item.cls == CLS_PLUS ||
                                             q_item.cls == CLS_MINUS)
                                    begin
                                        minus_seen_next = (q_item.cls == CLS_MINUS);
                                        phase_next      = NP_DIGITS;
                                    end
                                    else if (q_item.cls == CLS_DIGIT)
                                    begin
                                        acc_next   = acc_added;
                                        phase_next = NP_DIGITS;
                                    end
                                    else
                                    begin
                                        phase_next = NP_DONE;
                                    end
                                end
                                NP_DIGITS:
                                begin
                                    if (q_item.cls == CLS_DIGIT)
                                        acc_next = acc_added;
                                    else
                                        phase_next = NP_DONE;
                                end
                                default:
                                begin
                                    phase_next = NP_DONE;
                                end
                            endcase
                        end
                    end
                    else if (line_count_reg < LC_KEEP)
                    begin
                        line_count_next = line_count_reg + LC_W'(1);
                    end
                end
            endcase
            out_mask_next = lit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_min_reg <= PERIOD_MIN_RESET;
            period_max_reg <= PERIOD_MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PERIOD_MIN: period_min_reg <= cfg_data;
                CFG_PERIOD_MAX: period_max_reg <= cfg_data;
                default:        period_min_reg <= period_min_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg   <= '0;
            prefix_state_reg <= PS_L;
            prefix_bad_reg   <= 1'b0;
            target_led_reg   <= '0;
            phase_reg        <= NP_BLANKS;
            minus_seen_reg   <= 1'b0;
            acc_reg          <= '0;
            text_ended_reg   <= 1'b0;
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                period_reg[i]  <= PERIOD_RESET;
                half_reg[i]    <= HALF_RESET;
                elapsed_reg[i] <= '0;
            end
            lit_reg          <= '1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            line_count_reg   <= line_count_next;
            prefix_state_reg <= prefix_state_next;
            prefix_bad_reg   <= prefix_bad_next;
            target_led_reg   <= target_led_next;
            phase_reg        <= phase_next;
            minus_seen_reg   <= minus_seen_next;
            acc_reg          <= acc_next;
            text_ended_reg   <= text_ended_next;
            period_reg       <= period_next;
            half_reg         <= half_next;
            elapsed_reg      <= elapsed_next;
            lit_reg          <= lit_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_mask_reg   <= out_mask_next;
        out_status_reg <= out_status_next;
        out_led_reg    <= out_led_next;
        out_period_reg <= out_period_next;
    end

    a_accept_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == ST_ACCEPT |->
            out_period_reg >= period_min_reg && out_period_reg <= period_max_reg)
        else $error("Accepted period lies outside the configured limits.");

    a_no_cmd_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_ACCEPT |->
            out_led_reg == '0 && out_period_reg == '0)
        else $error("Command fields are set on an item that accepted no command.");

    a_line_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_count_reg <= LC_KEEP)
        else $error("Line count ran past the kept length.");

    a_prefix_bound: assert property (@(posedge clk) disable iff (!rst_n)
        prefix_state_reg <= PS_DONE)
        else $error("Prefix matcher ran past the end of the prefix.");

    a_tick_leaves_parser: assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_item.op == OP_TICK |=> $stable(line_count_reg) && $stable(acc_reg))
        else $error("A tick item changed the line parser.");

endmodule

/* rtl/led_blink_command_parser.sv */
// Top level of the LED blink command parser: front end, item queue and back end.
// Depends on lbcp_pkg, lbcp_front, lbcp_queue and lbcp_back.
//
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid / in_ready     kind, rx_data
//  out      output     out_valid / out_ready   led_mask, cmd_status, cmd_led, cmd_period
//  cfg      input      cfg_we                  cfg_index, cfg_data
//
// Each item produces exactly one result item; one item per cycle is sustained while
// out_ready is high. The back end finishes an item in the cycle it leaves the queue.
// Reset clears the parser, sets every period to 1000 ms and lights all LEDs.
// A stalled output holds one result; the two-entry queue takes items until it is full.
module led_blink_command_parser #(
    parameter int LINE_KEEP = lbcp_pkg::LINE_KEEP_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  kind,
    input  logic [7:0]                            rx_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [lbcp_pkg::NUM_LEDS-1:0]         led_mask,
    output logic [1:0]                            cmd_status,
    output logic [lbcp_pkg::LED_W-1:0]            cmd_led,
    output logic [lbcp_pkg::PERIOD_W-1:0]         cmd_period,
    input  logic                                  cfg_we,
    input  logic [lbcp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lbcp_pkg::PERIOD_W-1:0]         cfg_data
);
    import lbcp_pkg::*;

    logic  push;
    item_t push_item;
    logic  q_full;
    logic  q_valid;
    logic  pop;
    item_t q_item;

    lbcp_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .rx_data   (rx_data),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    lbcp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full),
        .q_valid   (q_valid),
        .pop       (pop),
        .q_item    (q_item)
    );

    lbcp_back #(
        .LINE_KEEP (LINE_KEEP)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .pop        (pop),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .led_mask   (led_mask),
        .cmd_status (cmd_status),
        .cmd_led    (cmd_led),
        .cmd_period (cmd_period)
    );

endmodule

/* tb/led_blink_command_parser_tb.sv */
// Testbench for led_blink_command_parser: directed table, then random command lines and ticks.
// Table or built-in predictor checks each result item; depends on lbcp_pkg and the RTL only.
`timescale 1ns / 100ps

module led_blink_command_parser_tb;
    import lbcp_pkg::*;

    typedef struct packed {
        logic [NUM_LEDS-1:0] mask;
        status_t             status;
        logic [LED_W-1:0]    led;
        logic [PERIOD_W-1:0] period;
    } blink_report_t;

    typedef struct packed {
        logic          k;
        logic [7:0]    ch;
        logic          typed;
        blink_report_t want;
    } stim_row_t;

    localparam blink_report_t NO_CHECK = '0;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 285;
    localparam int TICK_PCT = 30;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic kind = KIND_BYTE;
    logic [7:0] rx_data = 8'h00;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [NUM_LEDS-1:0] led_mask;
    logic [1:0] cmd_status;
    logic [LED_W-1:0] cmd_led;
    logic [PERIOD_W-1:0] cmd_period;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PERIOD_MIN;
    logic [PERIOD_W-1:0] cfg_data = '0;

    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned sent_items = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    blink_report_t expected_reports[$];

    // Predictor state.
    int unsigned line_len;
    logic [2:0] match_pos;
    logic prefix_fail;
    logic [LED_W-1:0] led_sel;
    phase_t num_phase;
    logic minus_sign;
    logic [ACC_W-1:0] acc;
    logic nul_seen;
    logic [PERIOD_W-1:0] blink_per [NUM_LEDS];
    logic [HALF_W-1:0] half_len [NUM_LEDS];
    logic [HALF_W-1:0] half_count [NUM_LEDS];
    logic [NUM_LEDS-1:0] lit_now;
    logic [PERIOD_W-1:0] lim_min;
    logic [PERIOD_W-1:0] lim_max;

    logic [PERIOD_W-1:0] phase_min [PHASES] = '{16'd0, 16'd50, 16'd0, 16'd65535, 16'd0, 16'd500};
    logic [PERIOD_W-1:0] phase_max [PHASES] =
        '{16'd65535, 16'd10000, 16'd3, 16'd65535, 16'd0, 16'd40};
    int unsigned phase_idle [PHASES] = '{0, 85, 0, 36, 0, 36};
    int unsigned phase_stall [PHASES] = '{0, 0, 85, 36, 85, 0};

    stim_row_t directed_rows [27] = '{
        '{KIND_TICK, 8'hFF, 1'b1, '{3'h7, ST_NONE, 2'd0, 16'd0}},
        '{KIND_BYTE, CHAR_LF, 1'b1, '{3'h7, ST_NONE, 2'd0, 16'd0}},
        '{KIND_BYTE, CHAR_L, 1'b0, NO_CHECK},
        '{KIND_BYTE, CHAR_E, 1'b0, NO_CHECK},
        '{KIND_BYTE, CHAR_D, 1'b0, NO_CHECK},
        '{KIND_BYTE, "3", 1'b0, NO_CHECK},
        '{KIND_BYTE, CHAR_COLON, 1'b0, NO_CHECK},
        '{KIND_BYTE, CHAR_TAB, 1'b0, NO_CHECK},
        '{KIND_BYTE, CHAR_PLUS, 1'b0, NO_CHECK},
        '{KIND_BYTE, "5", 1'b0, NO_CHECK},
        '{KIND_BYTE, "0", 1'b0, NO_CHECK},
        '{KIND_BYTE, CHAR_CR, 1'b1, '{3'h7, ST_ACCEPT, 2'd2, 16'd50}},
        '{KIND_BYTE, CHAR_NUL, 1'b0, NO_CHECK},
        '{KIND_BYTE, CHAR_LF, 1'b1, '{3'h7, ST_REJECT, 2'd0, 16'd0}},
        '{KIND_BYTE, 8'hFF, 1'b0, NO_CHECK},
        '{KIND_BYTE, CHAR_CR, 1'b1, '{3'h7, ST_REJECT, 2'd0, 16'd0}},
        '{KIND_BYTE, CHAR_L, 1'b0, NO_CHECK},
        '{KIND_BYTE, CHAR_E, 1'b0, NO_CHECK},
        '{KIND_BYTE, CHAR_D, 1'b0, NO_CHECK},
        '{KIND_BYTE, "2", 1'b0, NO_CHECK},
        '{KIND_BYTE, CHAR_COLON, 1'b0, NO_CHECK},
        '{KIND_BYTE, "1", 1'b0, NO_CHECK},
        '{KIND_BYTE, "0", 1'b0, NO_CHECK},
        '{KIND_BYTE, "0", 1'b0, NO_CHECK},
        '{KIND_BYTE, "0", 1'b0, NO_CHECK},
        '{KIND_BYTE, "0", 1'b0, NO_CHECK},
        '{KIND_BYTE, CHAR_LF, 1'b1, '{3'h7, ST_ACCEPT, 2'd1, 16'd10000}}
    };

    led_blink_command_parser dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .rx_data(rx_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .led_mask(led_mask),
        .cmd_status(cmd_status),
        .cmd_led(cmd_led),
        .cmd_period(cmd_period),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic clear_line();
        line_len = 0;
        match_pos = PS_L;
        prefix_fail = 1'b0;
        led_sel = '0;
        num_phase = NP_BLANKS;
        minus_sign = 1'b0;
        acc = '0;
        nul_seen = 1'b0;
    endtask

    task automatic reset_prediction();
        clear_line();
        lim_min = PERIOD_MIN_RESET;
        lim_max = PERIOD_MAX_RESET;
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            blink_per[i] = PERIOD_RESET;
            half_len[i] = HALF_RESET;
            half_count[i] = '0;
        end
        lit_now = '1;
    endtask

    task automatic add_digit(input logic [7:0] c);
        if (acc > ACC_LIMIT)
            acc = ACC_SAT;
        else
        begin
            acc = acc * ACC_W'(10) + ACC_W'(c - CHAR_ZERO);
            if (acc > ACC_SAT)
                acc = ACC_SAT;
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic ok;
        logic is_digit;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        if (nul_seen)
            return;
        if (c == CHAR_NUL)
        begin
            nul_seen = 1'b1;
            return;
        end
        if (match_pos < PS_DONE)
        begin
            if (prefix_fail)
                return;
            case (match_pos)
                PS_L: ok = (c == CHAR_L);
                PS_E: ok = (c == CHAR_E);
                PS_D: ok = (c == CHAR_D);
                PS_NUM:
                begin
                    ok = (c >= "1") && (c < 8'("1" + NUM_LEDS));
                    if (ok)
                        led_sel = LED_W'(c - "1");
                end
                default: ok = (c == CHAR_COLON);
            endcase
            if (ok)
                match_pos = match_pos + 3'd1;
            else
                prefix_fail = 1'b1;
            return;
        end
        if (num_phase == NP_BLANKS)
        begin
            if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF)
                return;
            if (c == CHAR_PLUS || c == CHAR_MINUS)
            begin
                minus_sign = (c == CHAR_MINUS);
                num_phase = NP_DIGITS;
            end
            else if (is_digit)
            begin
                add_digit(c);
                num_phase = NP_DIGITS;
            end
            else
                num_phase = NP_DONE;
        end
        else if (num_phase == NP_DIGITS)
        begin
            if (is_digit)
                add_digit(c);
            else
                num_phase = NP_DONE;
        end
    endtask

    task automatic predict_blink_step(input logic k, input logic [7:0] c,
                                      output blink_report_t r);
        logic cmd_ok;
        r = NO_CHECK;
        if (k == KIND_TICK)
        begin
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                half_count[i] = half_count[i] + 1'b1;
                if (half_count[i] >= half_len[i])
                begin
                    lit_now[i] = ~lit_now[i];
                    half_count[i] = '0;
                    half_len[i] = HALF_W'(blink_per[i] >> 1);
                end
            end
        end
        else if (c == CHAR_LF || c == CHAR_CR)
        begin
            if (line_len != 0)
            begin
                cmd_ok = (match_pos == PS_DONE) && !prefix_fail && !(minus_sign && acc != 0);
                if (cmd_ok && acc >= {1'b0, lim_min} && acc <= {1'b0, lim_max}
                    && led_sel < NUM_LEDS)
                begin
                    blink_per[led_sel] = acc[PERIOD_W-1:0];
                    r.status = ST_ACCEPT;
                    r.led = led_sel;
                    r.period = acc[PERIOD_W-1:0];
                end
                else
                    r.status = ST_REJECT;
                clear_line();
            end
        end
        else if (line_len < LINE_KEEP_DEF)
        begin
            line_len++;
            parse_char(c);
        end
        r.mask = lit_now;
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t: mismatch: %s", $realtime, what);
    endtask

    task automatic send_item(input logic k, input logic [7:0] d, input logic typed,
                             input blink_report_t want);
        blink_report_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        rx_data <= d;
        do
            @(posedge clk);
        while (!in_ready);
        sent_items++;
        predict_blink_step(k, d, predicted);
        expected_reports.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limits(input logic [PERIOD_W-1:0] lo, input logic [PERIOD_W-1:0] hi);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_PERIOD_MIN;
        cfg_data <= lo;
        @(negedge clk);
        cfg_index <= CFG_PERIOD_MAX;
        cfg_data <= hi;
        @(negedge clk);
        cfg_we <= 1'b0;
        lim_min = lo;
        lim_max = hi;
    endtask

    task automatic send_line();
        logic [7:0] text[$];
        int unsigned pick;
        int unsigned val;
        int unsigned top;
        string num;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(255)));
        end
        else
        begin
            text = '{CHAR_L, CHAR_E, CHAR_D};
            pick = $urandom_range(99);
            if (pick < 85)
                text.push_back(CHAR_ZERO + 8'($urandom_range(1, NUM_LEDS)));
            else if (pick < 93)
                text.push_back(CHAR_ZERO + 8'($urandom_range(NUM_LEDS + 1, 9)));
            else
                text.push_back(CHAR_ZERO);
            text.push_back($urandom_range(99) < 92 ? CHAR_COLON : 8'($urandom_range(255)));
            pick = $urandom_range(99);
            if (pick < 6)
                text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
            else if (pick < 11)
                while (text.size() > $urandom_range(1, 4))
                    void'(text.pop_back());
            if ($urandom_range(99) < 5)
                repeat (60) text.push_back(CHAR_SPACE);
            repeat ($urandom_range(0, 2))
            begin
                case ($urandom_range(3))
                    0: text.push_back(CHAR_SPACE);
                    1: text.push_back(CHAR_TAB);
                    2: text.push_back(CHAR_VT);
                    default: text.push_back(CHAR_FF);
                endcase
            end
            pick = $urandom_range(99);
            if (pick < 15)
                text.push_back(CHAR_PLUS);
            else if (pick < 30)
                text.push_back(CHAR_MINUS);
            pick = $urandom_range(99);
            if (pick < 30)
                val = $urandom_range(0, 9);
            else if (pick < 60 && lim_min <= lim_max)
            begin
                top = (lim_max - lim_min > 40) ? lim_min + 40 : lim_max;
                val = $urandom_range(top, lim_min);
            end
            else if (pick < 80)
                val = $urandom_range(65535);
            else if (pick < 90)
                val = $urandom_range(2000000000, 65536);
            if (pick < 90)
            begin
                num = $sformatf("%0d", val);
                if ($urandom_range(99) < 10)
                    num = {"00", num};
                for (int i = 0; i < num.len(); i++)
                    text.push_back(num[i]);
            end
            pick = $urandom_range(99);
            if (pick < 10)
                text.push_back(8'($urandom_range(255)));
            else if (pick < 16)
            begin
                text.push_back(CHAR_NUL);
                text.push_back(CHAR_ZERO + 8'($urandom_range(9)));
            end
        end
        text.push_back($urandom_range(1) ? CHAR_CR : CHAR_LF);
        if ($urandom_range(99) < 10)
            text.push_back($urandom_range(1) ? CHAR_CR : CHAR_LF);
        foreach (text[i])
        begin
            while ($urandom_range(99) < TICK_PCT)
                send_item(KIND_TICK, 8'($urandom_range(255)), 1'b0, NO_CHECK);
            send_item(KIND_BYTE, text[i], 1'b0, NO_CHECK);
        end
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : check_results
        blink_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reports.size() == 0)
                report_mismatch("result item with no item outstanding");
            else
            begin
                want = expected_reports.pop_front();
                if (led_mask !== want.mask)
                    report_mismatch($sformatf("led_mask %0h, expected %0h", led_mask, want.mask));
                if (cmd_status !== want.status)
                    report_mismatch($sformatf("cmd_status %0d, expected %0d",
                                              cmd_status, want.status));
                if (cmd_led !== want.led)
                    report_mismatch($sformatf("cmd_led %0d, expected %0d", cmd_led, want.led));
                if (cmd_period !== want.period)
                    report_mismatch($sformatf("cmd_period %0d, expected %0d",
                                              cmd_period, want.period));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned phase_end;
        reset_prediction();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].k, directed_rows[i].ch, directed_rows[i].typed,
                      directed_rows[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            write_limits(phase_min[p], phase_max[p]);
            idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            phase_end = sent_items + PHASE_ITEMS;
            while (sent_items < phase_end)
                send_line();
        end

        drain_results();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/lbcp_pkg.sv
rtl/lbcp_front.sv
rtl/lbcp_queue.sv
rtl/lbcp_back.sv
rtl/led_blink_command_parser.sv
tb/led_blink_command_parser_tb.sv
